FILE: rtl/core/ifrt_pkg.sv
// Shared types and constants of the IPv6 fragment reassembly tracker.
// Holds the queued command format, status codes and state encodings.
// No dependencies.
package ifrt_pkg;

	// Fixed field widths of a transaction
	localparam int SLOT_W       = 2;
	localparam int SLOT_RANGE   = 1 << SLOT_W;
	localparam int OFF_W        = 16;
	localparam int LEN_W        = 16;
	localparam int UNIT_SHIFT   = 3;
	localparam int START_W      = OFF_W - UNIT_SHIFT;
	localparam int END_W        = OFF_W + 1 - UNIT_SHIFT;
	localparam int TOTAL_W      = 17;
	localparam int STATUS_W     = 4;
	localparam int FCOUNT_W     = 5;
	localparam logic [UNIT_SHIFT-1:0] UNIT_MASK = 3'h7;
	localparam logic [LEN_W-1:0] HDR_LEN = 16'd8;

	// Pool record: owner, start unit, end unit
	localparam int REC_W = SLOT_W + START_W + END_W;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_PENDING   = 4'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 4'd1;
	localparam logic [STATUS_W-1:0] ST_COMPLETE  = 4'd2;
	localparam logic [STATUS_W-1:0] ST_UNFRAG    = 4'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd4;
	localparam logic [STATUS_W-1:0] ST_OVERLAP   = 4'd5;
	localparam logic [STATUS_W-1:0] ST_FULL      = 4'd6;
	localparam logic [STATUS_W-1:0] ST_NOT8      = 4'd7;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 4'd8;

	// Command classes decided by the front end
	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_EMPTY,
		CMD_NOSLOT,
		CMD_FRAG
	} cmd_kind_t;

	// Classified transaction as held in the queue
	typedef struct packed {
		cmd_kind_t              kind;
		logic [SLOT_W-1:0]      slot;
		logic                   slot_ok;
		logic [START_W-1:0]     istart;
		logic [END_W-1:0]       iend;
		logic [END_W-1:0]       width;
		logic                   off_nz;
		logic                   more;
		logic                   len_not8;
		logic [TOTAL_W-1:0]     add_len;
		logic [LEN_W-1:0]       unfrag_len;
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DRAIN,
		B_EXEC
	} back_state_t;

endpackage

FILE: rtl/core/ifrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module ifrt_ram #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/ifrt_front.sv
// Front end: classifies an incoming transaction and derives its interval.
// Depends on ifrt_pkg for the command format.
module ifrt_front #(
	parameter int SLOTS = 4
) (
	input  logic                          req_type,
	input  logic [ifrt_pkg::SLOT_W-1:0]   slot,
	input  logic [ifrt_pkg::OFF_W-1:0]    frag_offset,
	input  logic [ifrt_pkg::LEN_W-1:0]    frag_len,
	input  logic                          more_flag,
	input  logic [ifrt_pkg::LEN_W-1:0]    ip_payload_len,
	output ifrt_pkg::cmd_t                cmd
);

	logic [ifrt_pkg::START_W-1:0] unit_start;
	logic [ifrt_pkg::TOTAL_W-1:0] byte_end;
	logic [ifrt_pkg::END_W-1:0]   unit_end_raw;
	logic [ifrt_pkg::END_W-1:0]   unit_end;
	logic [ifrt_pkg::TOTAL_W-1:0] first_add;
	logic                         off_nz;
	logic                         slot_ok;

	// Convert bytes to 8-byte units, widening an empty interval by one unit
	assign unit_start   = frag_offset[ifrt_pkg::OFF_W-1:ifrt_pkg::UNIT_SHIFT];
	assign byte_end     = {1'b0, unit_start, {ifrt_pkg::UNIT_SHIFT{1'b0}}}
	                      + {1'b0, frag_len};
	assign unit_end_raw = byte_end[ifrt_pkg::TOTAL_W-1:ifrt_pkg::UNIT_SHIFT];
	assign unit_end     = (unit_end_raw == {1'b0, unit_start})
	                      ? unit_end_raw + ifrt_pkg::END_W'(1) : unit_end_raw;
	assign off_nz       = |unit_start;
	assign first_add    = {1'b0, ip_payload_len} - {1'b0, frag_len}
	                      - {1'b0, ifrt_pkg::HDR_LEN};
	assign slot_ok      = 32'(slot) < 32'(SLOTS);

	// Classify and pack the command
	always_comb begin
		if (req_type) begin
			cmd.kind = ifrt_pkg::CMD_CLEAR;
		end else if (frag_len == '0) begin
			cmd.kind = ifrt_pkg::CMD_EMPTY;
		end else if (!slot_ok) begin
			cmd.kind = ifrt_pkg::CMD_NOSLOT;
		end else begin
			cmd.kind = ifrt_pkg::CMD_FRAG;
		end
		cmd.slot       = slot;
		cmd.slot_ok    = slot_ok;
		cmd.istart     = unit_start;
		cmd.iend       = unit_end;
		cmd.width      = unit_end - {1'b0, unit_start};
		cmd.off_nz     = off_nz;
		cmd.more       = more_flag;
		cmd.len_not8   = |(frag_len[ifrt_pkg::UNIT_SHIFT-1:0] & ifrt_pkg::UNIT_MASK);
		cmd.add_len    = off_nz ? byte_end : first_add;
		cmd.unfrag_len = ip_payload_len - ifrt_pkg::HDR_LEN;
	end

endmodule

FILE: rtl/core/ifrt_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on ifrt_pkg for the command format.
module ifrt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ifrt_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ifrt_pkg::cmd_t  head_cmd
);

	ifrt_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_cmd   = entry_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue occupancy out of range");

endmodule

FILE: rtl/core/ifrt_back.sv
// Back end: scans the interval pool, updates slot state and issues results.
// Depends on ifrt_pkg and instantiates ifrt_ram for the pool records.
module ifrt_back #(
	parameter int SLOTS     = 4,
	parameter int INTERVALS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  ifrt_pkg::cmd_t                  q_cmd,
	output logic                            pop,
	output logic                            done,
	output logic [ifrt_pkg::STATUS_W-1:0]   status,
	output logic [ifrt_pkg::LEN_W-1:0]      datagram_len,
	output logic [ifrt_pkg::FCOUNT_W-1:0]   fragment_count
);

	localparam int IDX_W  = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
	localparam int CNT_W  = $clog2(INTERVALS + 1);
	localparam int NSLOT  = (SLOTS < ifrt_pkg::SLOT_RANGE) ? SLOTS : ifrt_pkg::SLOT_RANGE;
	localparam int SI_W   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(INTERVALS - 1);

	// Sequencer and scan state
	ifrt_pkg::back_state_t state_q, state_d;
	ifrt_pkg::cmd_t        cmd_q;
	ifrt_pkg::cmd_t        cur;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  cmp_v_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic                  dup_q, ov_q, found_q;
	logic [IDX_W-1:0]      free_idx_q;

	// Pool occupancy and ownership
	logic [INTERVALS-1:0]          valid_q;
	logic [ifrt_pkg::SLOT_W-1:0]   owner_q [INTERVALS];

	// Per-slot running state
	logic [ifrt_pkg::TOTAL_W-1:0]  total_q [NSLOT];
	logic                          last_q  [NSLOT];
	logic [ifrt_pkg::END_W-1:0]    sum_q   [NSLOT];
	logic [ifrt_pkg::END_W-1:0]    max_q   [NSLOT];
	logic [CNT_W-1:0]              fcnt_q  [NSLOT];

	// Result register
	logic                          done_q;
	logic [ifrt_pkg::STATUS_W-1:0] status_q;
	logic [ifrt_pkg::LEN_W-1:0]    dlen_q;
	logic [ifrt_pkg::FCOUNT_W-1:0] count_q;

	// Pool RAM and entry compare
	logic [ifrt_pkg::REC_W-1:0]    rdata;
	logic [ifrt_pkg::SLOT_W-1:0]   ent_own;
	logic [ifrt_pkg::START_W-1:0]  ent_st;
	logic [ifrt_pkg::END_W-1:0]    ent_en;
	logic                          ent_live, ent_dup, ent_ov;

	// Decision signals
	logic [SI_W-1:0]               si;
	logic                          rel_en, store_en, upd_total, set_last, out_en;
	logic [ifrt_pkg::STATUS_W-1:0] out_status;
	logic [ifrt_pkg::LEN_W-1:0]    out_dlen;
	logic [ifrt_pkg::FCOUNT_W-1:0] out_cnt;
	logic [ifrt_pkg::END_W-1:0]    sum_new, max_new;
	logic [CNT_W-1:0]              cnt_new;
	logic [ifrt_pkg::TOTAL_W-1:0]  total_new;
	logic                          last_new, complete;

	ifrt_ram #(
		.WIDTH (ifrt_pkg::REC_W),
		.DEPTH (INTERVALS)
	) u_pool (
		.clk   (clk),
		.we    (store_en),
		.waddr (free_idx_q),
		.wdata ({cmd_q.slot, cmd_q.istart, cmd_q.iend}),
		.re    (state_q == ifrt_pkg::B_SCAN),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	// Compare the record read in the previous cycle against the fragment
	assign ent_own  = rdata[ifrt_pkg::REC_W-1 -: ifrt_pkg::SLOT_W];
	assign ent_st   = rdata[ifrt_pkg::END_W +: ifrt_pkg::START_W];
	assign ent_en   = rdata[ifrt_pkg::END_W-1:0];
	assign ent_live = cmp_v_s1 && valid_q[cmp_idx_s1] && (ent_own == cmd_q.slot);
	assign ent_dup  = ent_live && (ent_st == cmd_q.istart) && (ent_en == cmd_q.iend);
	assign ent_ov   = ent_live && !ent_dup && ({1'b0, ent_st} < cmd_q.iend)
	                  && ({1'b0, cmd_q.istart} < ent_en);

	// Select the command in hand and its slot state
	assign cur       = (state_q == ifrt_pkg::B_IDLE) ? q_cmd : cmd_q;
	assign si        = SI_W'(cur.slot);
	assign sum_new   = sum_q[si] + cur.width;
	assign max_new   = (cur.iend > max_q[si]) ? cur.iend : max_q[si];
	assign cnt_new   = fcnt_q[si] + CNT_W'(1);
	assign total_new = upd_total ? total_q[si] + cur.add_len : total_q[si];
	assign last_new  = last_q[si] | set_last;
	// Disjoint intervals whose widths add up to the highest end cover it from zero
	assign complete  = last_new && (sum_new == max_new);

	// Next state and transaction decisions
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		rel_en     = 1'b0;
		store_en   = 1'b0;
		upd_total  = 1'b0;
		set_last   = 1'b0;
		out_en     = 1'b0;
		out_status = ifrt_pkg::ST_PENDING;
		out_dlen   = '0;
		out_cnt    = '0;
		case (state_q)
			ifrt_pkg::B_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					case (cur.kind)
						ifrt_pkg::CMD_FRAG: begin
							state_d = ifrt_pkg::B_SCAN;
						end
						ifrt_pkg::CMD_CLEAR: begin
							rel_en     = cur.slot_ok;
							out_en     = 1'b1;
							out_status = ifrt_pkg::ST_CLEARED;
						end
						ifrt_pkg::CMD_EMPTY: begin
							out_en     = 1'b1;
							out_status = ifrt_pkg::ST_EMPTY;
						end
						default: begin
							out_en     = 1'b1;
							out_status = ifrt_pkg::ST_FULL;
						end
					endcase
				end
			end
			ifrt_pkg::B_SCAN: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = ifrt_pkg::B_DRAIN;
				end
			end
			ifrt_pkg::B_DRAIN: begin
				state_d = ifrt_pkg::B_EXEC;
			end
			ifrt_pkg::B_EXEC: begin
				state_d = ifrt_pkg::B_IDLE;
				out_en  = 1'b1;
				if (dup_q) begin
					out_status = ifrt_pkg::ST_DUPLICATE;
				end else if (ov_q) begin
					rel_en     = 1'b1;
					out_status = ifrt_pkg::ST_OVERLAP;
				end else if (!found_q) begin
					rel_en     = 1'b1;
					out_status = ifrt_pkg::ST_FULL;
				end else begin
					store_en = 1'b1;
					if (cur.off_nz && cur.more && cur.len_not8) begin
						rel_en     = 1'b1;
						out_status = ifrt_pkg::ST_NOT8;
					end else if (!cur.off_nz && !cur.more) begin
						rel_en     = 1'b1;
						out_status = ifrt_pkg::ST_UNFRAG;
						out_dlen   = cur.unfrag_len;
						out_cnt    = ifrt_pkg::FCOUNT_W'(1);
					end else if (!cur.off_nz && cur.len_not8) begin
						rel_en     = 1'b1;
						out_status = ifrt_pkg::ST_NOT8;
					end else begin
						set_last  = cur.off_nz && !cur.more;
						upd_total = !(cur.off_nz && cur.more);
						if (complete) begin
							rel_en     = 1'b1;
							out_status = ifrt_pkg::ST_COMPLETE;
							out_dlen   = total_new[ifrt_pkg::LEN_W-1:0];
							out_cnt    = ifrt_pkg::FCOUNT_W'(cnt_new);
						end
					end
				end
			end
			default: begin
				state_d = ifrt_pkg::B_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifrt_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the fragment under work
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
	end

	// Advance the pool scan and gather duplicate, overlap and free-entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			cmp_v_s1   <= 1'b0;
			cmp_idx_s1 <= '0;
			dup_q      <= 1'b0;
			ov_q       <= 1'b0;
			found_q    <= 1'b0;
			free_idx_q <= '0;
		end else begin
			cmp_v_s1   <= state_q == ifrt_pkg::B_SCAN;
			cmp_idx_s1 <= rd_idx_q;
			if (pop) begin
				rd_idx_q <= '0;
				dup_q    <= 1'b0;
				ov_q     <= 1'b0;
				found_q  <= 1'b0;
			end else begin
				if (ent_dup) begin
					dup_q <= 1'b1;
				end
				if (ent_ov) begin
					ov_q <= 1'b1;
				end
				if (state_q == ifrt_pkg::B_SCAN) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
					if (!found_q && !valid_q[rd_idx_q]) begin
						found_q    <= 1'b1;
						free_idx_q <= rd_idx_q;
					end
				end
			end
		end
	end

	// Claim a pool entry, or drop every entry of a released slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < INTERVALS; i++) begin
				if (rel_en && (owner_q[i] == cur.slot)) begin
					valid_q[i] <= 1'b0;
				end else if (store_en && !rel_en && (IDX_W'(i) == free_idx_q)) begin
					valid_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			owner_q[free_idx_q] <= cmd_q.slot;
		end
	end

	// Update or zero the slot's running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSLOT; k++) begin
				total_q[k] <= '0;
				last_q[k]  <= 1'b0;
				sum_q[k]   <= '0;
				max_q[k]   <= '0;
				fcnt_q[k]  <= '0;
			end
		end else if (rel_en) begin
			total_q[si] <= '0;
			last_q[si]  <= 1'b0;
			sum_q[si]   <= '0;
			max_q[si]   <= '0;
			fcnt_q[si]  <= '0;
		end else if (store_en) begin
			total_q[si] <= total_new;
			last_q[si]  <= last_new;
			sum_q[si]   <= sum_new;
			max_q[si]   <= max_new;
			fcnt_q[si]  <= cnt_new;
		end
	end

	// Present each result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= out_en;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			status_q <= out_status;
			dlen_q   <= out_dlen;
			count_q  <= out_cnt;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign datagram_len   = dlen_q;
	assign fragment_count = count_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ifrt_pkg::B_EXEC || state_q == ifrt_pkg::B_IDLE))
		else $error("result issued outside idle or execute");
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_s1 |-> (state_q == ifrt_pkg::B_SCAN || state_q == ifrt_pkg::B_DRAIN))
		else $error("pool compare outside the scan");
	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		store_en |-> !valid_q[free_idx_q])
		else $error("pool entry claimed while in use");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ifrt_pkg::B_IDLE && q_valid))
		else $error("command taken while busy");

endmodule

FILE: rtl/core/ipv6_fragment_reassembly_tracker_core.sv
// Top level of the IPv6 fragment reassembly tracker.
// Depends on ifrt_pkg; instantiates ifrt_front, ifrt_queue and ifrt_back.

// A transaction is taken when start is high and busy is low; every transaction
// gives exactly one result, shown for one cycle with done high, in arrival
// order. The receiver cannot stall, so done must be sampled every cycle.
// A front end classifies each transaction into a two-entry queue; busy rises
// only while that queue is full. Clear, empty and out-of-range transactions
// give their result from the idle state when the back end is free. A fragment
// is scanned, drained and executed by the back end: the pool records sit in one
// RAM with a single registered read port, scanned one entry a cycle for
// duplicates, overlaps and the first free entry, then updated in the execute state.
// Pool valid bits reset at once; no clearing pass follows reset.
module ipv6_fragment_reassembly_tracker_core #(
	parameter int SLOTS     = 4,
	parameter int INTERVALS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [ifrt_pkg::SLOT_W-1:0]     slot,
	input  logic [ifrt_pkg::OFF_W-1:0]      frag_offset,
	input  logic [ifrt_pkg::LEN_W-1:0]      frag_len,
	input  logic                            more_flag,
	input  logic [ifrt_pkg::LEN_W-1:0]      ip_payload_len,
	output logic                            done,
	output logic [ifrt_pkg::STATUS_W-1:0]   status,
	output logic [ifrt_pkg::LEN_W-1:0]      datagram_len,
	output logic [ifrt_pkg::FCOUNT_W-1:0]   fragment_count
);

	ifrt_pkg::cmd_t front_cmd;
	ifrt_pkg::cmd_t head_cmd;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	logic           push;

	// Accept a transaction whenever the queue has room
	assign busy = q_full;
	assign push = start && !q_full;

	ifrt_front #(
		.SLOTS (SLOTS)
	) u_front (
		.req_type       (req_type),
		.slot           (slot),
		.frag_offset    (frag_offset),
		.frag_len       (frag_len),
		.more_flag      (more_flag),
		.ip_payload_len (ip_payload_len),
		.cmd            (front_cmd)
	);

	ifrt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (front_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (head_cmd)
	);

	ifrt_back #(
		.SLOTS     (SLOTS),
		.INTERVALS (INTERVALS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_cmd          (head_cmd),
		.pop            (q_pop),
		.done           (done),
		.status         (status),
		.datagram_len   (datagram_len),
		.fragment_count (fragment_count)
	);

endmodule
